@@ rtl/amas_pkg.sv @@
// Shared types and constants for the audio mix accumulate/saturate core.
// Depends on nothing; every other file of the core but amas_ram imports it.
package amas_pkg;

  // Field widths of the input and result words
  localparam int unsigned SLOT_W    = 9;
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned VOLUME_W  = 8;
  localparam int unsigned PAN_W     = 8;
  localparam int unsigned OUT_W     = 16;
  localparam int unsigned ACC_W     = 32;

  // Stream word widths (fields packed from bit 0, padded to bytes)
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 32;

  // Datapath widths
  localparam int unsigned PROD_W = SAMPLE_W + VOLUME_W + 1; // signed sample * volume
  localparam int unsigned MAG1_W = SAMPLE_W + VOLUME_W;     // |sample * volume|
  localparam int unsigned SCL_W  = MAG1_W + 1;              // signed scaled sample
  localparam int unsigned WGT_W  = PAN_W;                   // signed pan weight
  localparam int unsigned T_W    = SCL_W + WGT_W;           // signed scaled * weight
  localparam int unsigned TMAG_W = 30;                      // |scaled * weight| < 2^30

  // Pan weight full scale and its exact reciprocal for the divide
  localparam int              PAN_FULL = 100;
  localparam int unsigned     PAN_L    = $clog2(PAN_FULL);
  localparam int unsigned     PAN_SH   = TMAG_W + PAN_L;
  localparam int unsigned     PAN_M_W  = TMAG_W + 1;
  localparam longint unsigned PAN_M    =
      ((64'd1 << PAN_SH) + 64'(PAN_FULL) - 64'd1) / 64'(PAN_FULL);

  // Saturation bounds of the drained sample
  localparam logic signed [ACC_W-1:0] OUT_MAX = 32'sd32767;
  localparam logic signed [ACC_W-1:0] OUT_MIN = -32'sd32768;

  typedef enum logic {
    OP_ACC   = 1'b0,
    OP_DRAIN = 1'b1
  } op_e;

  // Control that travels down the pipeline with each word
  typedef struct packed {
    logic              valid;
    op_e               op;
    logic [SLOT_W-1:0] slot;
    logic              in_range;
  } ctrl_t;

  // Word handed from the scaling pipeline to the accumulate stage
  typedef struct packed {
    ctrl_t                    ctrl;
    logic signed [SCL_W-1:0]  scaled;
  } item_t;

endpackage

@@ rtl/amas_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Read-first on an address collision; no dependencies.
module amas_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/amas_scale.sv @@
// Four-stage scaling pipeline: volume multiply, volume divide, pan weight
// multiply, pan divide. Divides use exact reciprocal multiplies. Uses amas_pkg.
module amas_scale
  import amas_pkg::*;
#(
  parameter int unsigned MIX_SLOTS   = 512,
  parameter int unsigned FULL_VOLUME = 100
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       adv_i,
  input  logic                       in_valid_i,
  input  op_e                        in_op_i,
  input  logic [SLOT_W-1:0]          in_slot_i,
  input  logic signed [SAMPLE_W-1:0] in_sample_i,
  input  logic [VOLUME_W-1:0]        in_volume_i,
  input  logic signed [PAN_W-1:0]    in_pan_i,
  output item_t                      item_o
);

  // Exact reciprocal of the volume full scale for dividends below 2^MAG1_W
  localparam int unsigned     VOL_L   = $clog2(FULL_VOLUME);
  localparam int unsigned     VOL_SH  = MAG1_W + VOL_L;
  localparam int unsigned     VOL_M_W = MAG1_W + 1;
  localparam longint unsigned VOL_M   =
      ((64'd1 << VOL_SH) + 64'(FULL_VOLUME) - 64'd1) / 64'(FULL_VOLUME);
  localparam int unsigned     MUL1_W  = MAG1_W + VOL_M_W;
  localparam int unsigned     MUL2_W  = TMAG_W + PAN_M_W;

  ctrl_t c1_d, c1_q, c2_q, c3_q, c4_q;

  // Stage 1: clamp volume, multiply, derive pan weight
  logic [VOLUME_W-1:0]       vol_clamp;
  logic signed [PROD_W-1:0]  samp_ext, vol_ext, prod1_d, prod1_q;
  logic                      pan_neg, weigh;
  logic [PAN_W-1:0]          pan_mag;
  logic signed [WGT_W-1:0]   wgt1_d, wgt1_q, wgt2_q;

  always_comb begin
    vol_clamp = (in_volume_i > VOLUME_W'(FULL_VOLUME)) ? VOLUME_W'(FULL_VOLUME) : in_volume_i;
    samp_ext  = PROD_W'(in_sample_i);
    vol_ext   = signed'(PROD_W'(vol_clamp));
    prod1_d   = samp_ext * vol_ext;
    pan_neg   = in_pan_i[PAN_W-1];
    pan_mag   = pan_neg ? PAN_W'(-in_pan_i) : PAN_W'(in_pan_i);
    weigh     = (pan_neg && in_slot_i[0]) ||
                (!pan_neg && (in_pan_i != '0) && !in_slot_i[0]);
    wgt1_d    = weigh ? WGT_W'(PAN_FULL - int'(pan_mag)) : WGT_W'(PAN_FULL);
    c1_d.valid    = in_valid_i;
    c1_d.op       = in_op_i;
    c1_d.slot     = in_slot_i;
    c1_d.in_range = (32'(in_slot_i) < MIX_SLOTS);
  end

  // Stage 2: divide |product| by full volume
  logic                  neg1;
  logic [MAG1_W-1:0]     mag1, q2_d, q2_q;
  logic [MUL1_W-1:0]     mul1;
  logic                  neg2_q;

  always_comb begin
    neg1 = prod1_q[PROD_W-1];
    mag1 = neg1 ? MAG1_W'(-prod1_q) : MAG1_W'(prod1_q);
    mul1 = MUL1_W'(mag1) * MUL1_W'(VOL_M);
    q2_d = MAG1_W'(mul1 >> VOL_SH);
  end

  // Stage 3: restore sign, multiply by pan weight, take magnitude
  logic signed [SCL_W-1:0] q_ext, s3;
  logic signed [T_W-1:0]   s_wide, w_wide, t3, t3_abs;
  logic                    tneg_d, tneg_q;
  logic [TMAG_W-1:0]       tmag_d, tmag_q;

  always_comb begin
    q_ext  = signed'({1'b0, q2_q});
    s3     = neg2_q ? -q_ext : q_ext;
    s_wide = T_W'(s3);
    w_wide = T_W'(wgt2_q);
    t3     = s_wide * w_wide;
    tneg_d = t3[T_W-1];
    t3_abs = tneg_d ? -t3 : t3;
    tmag_d = t3_abs[TMAG_W-1:0];
  end

  // Stage 4: divide by pan full scale, restore sign
  logic [MUL2_W-1:0]       mul2;
  logic signed [SCL_W-1:0] u_ext, scaled_d, scaled_q;

  always_comb begin
    mul2     = MUL2_W'(tmag_q) * MUL2_W'(PAN_M);
    u_ext    = signed'({1'b0, MAG1_W'(mul2 >> PAN_SH)});
    scaled_d = tneg_q ? -u_ext : u_ext;
  end

  // Advance control down the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= '0;
      c2_q <= '0;
      c3_q <= '0;
      c4_q <= '0;
    end else if (adv_i) begin
      c1_q <= c1_d;
      c2_q <= c1_q;
      c3_q <= c2_q;
      c4_q <= c3_q;
    end
  end

  // Advance payload down the pipeline
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      prod1_q  <= prod1_d;
      wgt1_q   <= wgt1_d;
      q2_q     <= q2_d;
      neg2_q   <= neg1;
      wgt2_q   <= wgt1_q;
      tmag_q   <= tmag_d;
      tneg_q   <= tneg_d;
      scaled_q <= scaled_d;
    end
  end

  assign item_o.ctrl   = c4_q;
  assign item_o.scaled = scaled_q;

endmodule

@@ rtl/amas_acc.sv @@
// Accumulate stage: mix buffer RAM, read-modify-write with one-deep write
// forwarding, drain saturation, result register and post-reset clear pass.
// Uses amas_pkg and amas_ram.
module amas_acc
  import amas_pkg::*;
#(
  parameter int unsigned MIX_SLOTS = 512
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     adv_i,
  input  item_t                    item_i,
  output logic                     busy_o,
  output logic                     out_valid_o,
  output logic signed [OUT_W-1:0]  out_sample_o,
  output logic [SLOT_W-1:0]        out_slot_o
);

  localparam int unsigned ADDR_W = $clog2(MIX_SLOTS);

  ctrl_t                   c5_q;
  logic signed [SCL_W-1:0] scaled5_q;
  logic [ACC_W-1:0]        rdata;
  logic [ADDR_W-1:0]       addr5;
  logic signed [ACC_W-1:0] acc_cur, acc_sum, wdata_item, sat;
  logic                    wen_item;
  logic                    fwd_valid_q;
  logic [ADDR_W-1:0]       fwd_addr_q;
  logic [ACC_W-1:0]        fwd_data_q;
  logic                    clr_busy_q;
  logic [ADDR_W-1:0]       clr_cnt_q;
  logic                    ram_we;
  logic [ADDR_W-1:0]       ram_waddr;
  logic [ACC_W-1:0]        ram_wdata;
  logic                    out_valid_q;
  logic signed [OUT_W-1:0] out_sample_q;
  logic [SLOT_W-1:0]       out_slot_q;

  amas_ram #(
    .WIDTH (ACC_W),
    .DEPTH (MIX_SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (adv_i),
    .raddr_i (ADDR_W'(item_i.ctrl.slot)),
    .rdata_o (rdata)
  );

  // Pick the current slot value, add or saturate
  always_comb begin
    addr5      = ADDR_W'(c5_q.slot);
    acc_cur    = (fwd_valid_q && (fwd_addr_q == addr5)) ? fwd_data_q : rdata;
    acc_sum    = acc_cur + ACC_W'(scaled5_q);
    wen_item   = adv_i && c5_q.valid && c5_q.in_range;
    wdata_item = (c5_q.op == OP_DRAIN) ? '0 : acc_sum;
    if (acc_cur > OUT_MAX) begin
      sat = OUT_MAX;
    end else if (acc_cur < OUT_MIN) begin
      sat = OUT_MIN;
    end else begin
      sat = acc_cur;
    end
  end

  // Share the write port between the clear pass and the pipeline
  always_comb begin
    ram_we    = clr_busy_q || wen_item;
    ram_waddr = clr_busy_q ? clr_cnt_q : addr5;
    ram_wdata = clr_busy_q ? '0 : wdata_item;
  end

  // Sweep the buffer to zero after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      if (clr_cnt_q == ADDR_W'(MIX_SLOTS - 1)) begin
        clr_busy_q <= 1'b0;
      end else begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
    end
  end

  // Advance stage control, forwarding valid and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c5_q        <= '0;
      fwd_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv_i) begin
      c5_q        <= item_i.ctrl;
      fwd_valid_q <= c5_q.valid && c5_q.in_range;
      out_valid_q <= c5_q.valid && (c5_q.op == OP_DRAIN);
    end
  end

  // Advance payload, forwarding word and result word
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      scaled5_q    <= item_i.scaled;
      fwd_addr_q   <= addr5;
      fwd_data_q   <= wdata_item;
      out_sample_q <= c5_q.in_range ? OUT_W'(sat) : '0;
      out_slot_q   <= c5_q.slot;
    end
  end

  assign busy_o       = clr_busy_q;
  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_sample_q;
  assign out_slot_o   = out_slot_q;

endmodule

@@ rtl/audio_mix_accumulate_saturate_core.sv @@
// Top level of the audio mix accumulate/saturate core: stream ports,
// pipeline advance control. Uses amas_pkg, amas_scale and amas_acc.
//
//  channel  | dir | tdata fields (low bit up)                     | tuser
//  s_axis   | in  | slot[8:0] sample[24:9] volume[32:25] pan[40:33] | operation
//  m_axis   | out | mixed_sample[15:0] out_slot[24:16]             | -
//
// One word is accepted per cycle while the core is neither clearing nor stalled; a
// drain's result passes four scaling stages, the accumulate stage and the result
// register. After reset the mix buffer is cleared one slot per cycle, and
// s_axis_tready_o stays low until every slot is cleared.
// A result held by m_axis_tready_i low freezes the whole pipeline, which
// drops s_axis_tready_o for as long as the stall lasts.
module audio_mix_accumulate_saturate_core
  import amas_pkg::*;
#(
  parameter int unsigned MIX_SLOTS   = 512,
  parameter int unsigned FULL_VOLUME = 100
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,  // slot, sample, volume, pan
  input  logic                  s_axis_tuser_i,  // operation
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o   // mixed_sample, out_slot
);

  logic                    adv;
  logic                    busy;
  item_t                   item4;
  logic                    out_valid;
  logic signed [OUT_W-1:0] out_sample;
  logic [SLOT_W-1:0]       out_slot;

  // Advance while the result register is free or being taken
  assign adv             = !out_valid || m_axis_tready_i;
  assign s_axis_tready_o = adv && !busy;

  amas_scale #(
    .MIX_SLOTS   (MIX_SLOTS),
    .FULL_VOLUME (FULL_VOLUME)
  ) u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .in_valid_i  (s_axis_tvalid_i && s_axis_tready_o),
    .in_op_i     (op_e'(s_axis_tuser_i)),
    .in_slot_i   (s_axis_tdata_i[8:0]),
    .in_sample_i (signed'(s_axis_tdata_i[24:9])),
    .in_volume_i (s_axis_tdata_i[32:25]),
    .in_pan_i    (signed'(s_axis_tdata_i[40:33])),
    .item_o      (item4)
  );

  amas_acc #(
    .MIX_SLOTS (MIX_SLOTS)
  ) u_acc (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .item_i       (item4),
    .busy_o       (busy),
    .out_valid_o  (out_valid),
    .out_sample_o (out_sample),
    .out_slot_o   (out_slot)
  );

  // Pack the result word
  assign m_axis_tvalid_o = out_valid;
  assign m_axis_tdata_o  = {(OUT_DATA_W - OUT_W - SLOT_W)'(0), out_slot, out_sample};

endmodule

@@ rtl/amas_chk.sv @@
// Port-level checker for the audio mix accumulate/saturate core, with the
// bind that attaches it to the top level. Uses amas_pkg.
module amas_chk
  import amas_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tready_o,
  input logic                  m_axis_tvalid_o,
  input logic                  m_axis_tready_i,
  input logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result word changed or dropped");

  // Refuse input while the result register is stalled
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |-> !s_axis_tready_o)
    else $error("input accepted while output stalled");

  // Idle input with empty output means the clear pass: no result can appear
  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o && !m_axis_tvalid_o |=> !m_axis_tvalid_o)
    else $error("result appeared during clear pass");

  // Keep result padding at zero
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[OUT_DATA_W-1:OUT_W+SLOT_W] == '0)
    else $error("result padding not zero");

endmodule

bind audio_mix_accumulate_saturate_core amas_chk u_amas_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

@@ bench/audio_mix_accumulate_saturate_core_tb.sv @@
// Self-checking testbench for audio_mix_accumulate_saturate_core.
// Holds its own mix-buffer model and compares every drained word with it.
// Depends on amas_pkg and the core RTL only.
`timescale 1ns / 1ps

module audio_mix_accumulate_saturate_core_tb;
  import amas_pkg::*;

  localparam int MIX_FULL_VOL  = 100;
  localparam int WEIGHT_FULL   = 100;
  localparam int SAT_HI        = 32767;
  localparam int SAT_LO        = -32768;
  localparam int BUF_DEPTH     = 512;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 20;
  localparam int MAX_REPORTS   = 10;

  // One drained word as it should come out
  typedef struct packed {
    logic signed [15:0] mixed;
    logic [8:0]         slot;
  } drain_word_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  s_valid = 1'b0;
  logic                  s_ready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_valid;
  logic                  m_ready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  // Model state: one 32-bit accumulator per slot, zero after reset
  logic [31:0]  mix_acc [BUF_DEPTH];
  drain_word_t  drained_q [$];

  int  err_cnt = 0;
  int  mismatch_cnt = 0;
  bit  src_idle_en = 1'b0;
  bit  snk_idle_en = 1'b0;
  bit  hold_req = 1'b0;

  audio_mix_accumulate_saturate_core DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_tdata),  // slot, sample, volume, pan
    .s_axis_tuser_i  (s_tuser),  // operation
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_tdata)   // mixed_sample, out_slot
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Generous run limit
  initial begin
    #1_000_000;
    $display("** audio_mix_accumulate_saturate_core: FAILED **");
    $finish;
  end

  initial begin
    for (int k = 0; k < BUF_DEPTH; k++) mix_acc[k] = '0;
  end

  // Advance the mix-buffer model by one accepted word
  task automatic mix_model_step(input op_e op, input logic [8:0] slot,
                                input logic signed [15:0] sample,
                                input logic [7:0] volume,
                                input logic signed [7:0] pan);
    int          vol_c;
    int          scaled;
    int          mag;
    int          acc_s;
    drain_word_t res;
    if (op == OP_ACC) begin
      vol_c = (int'(volume) > MIX_FULL_VOL) ? MIX_FULL_VOL : int'(volume);
      scaled = (int'(sample) * vol_c) / MIX_FULL_VOL;
      // Pan weight hits odd slots for negative pan, even slots for positive
      if ((pan < 0 && slot[0]) || (pan > 0 && !slot[0])) begin
        mag = (pan < 0) ? -int'(pan) : int'(pan);
        scaled = (scaled * (WEIGHT_FULL - mag)) / WEIGHT_FULL;
      end
      mix_acc[slot] = mix_acc[slot] + 32'(scaled);
    end else begin
      acc_s = int'(mix_acc[slot]);
      mix_acc[slot] = '0;
      if (acc_s > SAT_HI) acc_s = SAT_HI;
      else if (acc_s < SAT_LO) acc_s = SAT_LO;
      res.mixed = 16'(acc_s);
      res.slot = slot;
      drained_q.push_back(res);
    end
  endtask

  // Offer one word, wait for it to be taken, then update the model
  task automatic send_word(input op_e op, input logic [8:0] slot,
                           input logic signed [15:0] sample,
                           input logic [7:0] volume,
                           input logic signed [7:0] pan);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {7'b0, pan, volume, sample, slot};
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    mix_model_step(op, slot, sample, volume, pan);
  endtask

  // Random word: hot slots keep drains landing on filled accumulators
  task automatic send_random_word(input int drain_pct);
    op_e               op;
    logic [8:0]        slot;
    logic signed [15:0] sample;
    logic [7:0]        volume;
    logic signed [7:0] pan;
    op = ($urandom_range(0, 99) < drain_pct) ? OP_DRAIN : OP_ACC;
    slot = ($urandom_range(0, 9) < 7) ? 9'($urandom_range(0, 15)) : 9'($urandom);
    case ($urandom_range(0, 9))
      0:       sample = 16'sh7FFF;
      1:       sample = 16'sh8000;
      default: sample = 16'($urandom);
    endcase
    case ($urandom_range(0, 7))
      0:       volume = 8'd0;
      1:       volume = 8'd255;
      2:       volume = 8'd100;
      default: volume = 8'($urandom);
    endcase
    case ($urandom_range(0, 3))
      0:       pan = 8'sd0;
      1:       pan = 8'($urandom);
      default: pan = 8'($urandom_range(0, 200) - 100);
    endcase
    send_word(op, slot, sample, volume, pan);
  endtask

  // Drop valid, then wait until every drained word has come out
  task automatic wait_drained();
    s_valid <= 1'b0;
    @(posedge clk);
    while (drained_q.size() != 0) @(posedge clk);
  endtask

  // Extremes, clamping, pan sides, weights out of range, saturation
  task automatic test_directed();
    send_word(OP_DRAIN, 9'd0,   16'sd0,      8'd0,   8'sd0);
    send_word(OP_ACC,   9'd511, 16'sd32767,  8'd255, 8'sd0);
    send_word(OP_ACC,   9'd511, 16'sd32767,  8'd255, 8'sd0);
    send_word(OP_DRAIN, 9'd511, 16'sd0,      8'd0,   8'sd0);
    send_word(OP_ACC,   9'd2,   -16'sd32768, 8'd100, 8'sd0);
    send_word(OP_ACC,   9'd2,   -16'sd32768, 8'd100, 8'sd0);
    send_word(OP_DRAIN, 9'd2,   16'sd0,      8'd0,   8'sd0);
    // zero volume leaves the slot alone
    send_word(OP_ACC,   9'd3,   16'sd12345,  8'd0,   8'sd0);
    send_word(OP_DRAIN, 9'd3,   16'sd0,      8'd0,   8'sd0);
    send_word(OP_ACC,   9'd5,   16'sd30001,  8'd77,  -8'sd100);
    send_word(OP_ACC,   9'd5,   -16'sd1000,  8'd99,  -8'sd37);
    send_word(OP_DRAIN, 9'd5,   16'sd0,      8'd0,   8'sd0);
    send_word(OP_ACC,   9'd4,   16'sd30001,  8'd100, 8'sd100);
    send_word(OP_ACC,   9'd4,   16'sd20000,  8'd50,  8'sd55);
    send_word(OP_ACC,   9'd4,   -16'sd7777,  8'd100, -8'sd55);
    send_word(OP_DRAIN, 9'd4,   16'sd0,      8'd0,   8'sd0);
    // pan past full scale gives a negative weight
    send_word(OP_ACC,   9'd7,   16'sd25000,  8'd100, -8'sd128);
    send_word(OP_ACC,   9'd7,   -16'sd25000, 8'd255, 8'sd127);
    send_word(OP_DRAIN, 9'd7,   16'sd0,      8'd0,   8'sd0);
    send_word(OP_ACC,   9'd6,   16'sd32767,  8'd100, 8'sd127);
    send_word(OP_DRAIN, 9'd6,   16'sd0,      8'd0,   8'sd0);
    // small negative product truncates toward zero
    send_word(OP_ACC,   9'd8,   -16'sd3,     8'd33,  8'sd1);
    send_word(OP_DRAIN, 9'd8,   16'sd0,      8'd0,   8'sd0);
  endtask

  // Random words in chunks, idling switched per chunk
  task automatic test_random_mix();
    for (int c = 0; c < 23; c++) begin
      src_idle_en = ($urandom_range(0, 3) != 0);
      snk_idle_en = ($urandom_range(0, 3) != 0);
      for (int n = 0; n < 50; n++) send_random_word(25);
    end
  endtask

  // Long receiver stall fills the pipe, then pause until all words are out
  task automatic test_backpressure();
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    hold_req = 1'b1;
    for (int n = 0; n < 100; n++) send_random_word(50);
    wait_drained();
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;
    for (int n = 0; n < 20; n++) send_random_word(25);
  endtask

  // Back-to-back words at full rate
  task automatic test_full_rate();
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    for (int n = 0; n < 460; n++) send_random_word(25);
  endtask

  // Receiver: random stall bursts, or one long hold when requested
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_ready <= 1'b0;
        for (int n = 1; n < HOLD_CYCLES; n++) @(posedge clk);
        hold_req = 1'b0;
      end else if (snk_idle_en && $urandom_range(0, 5) == 0) begin
        m_ready <= 1'b0;
        repeat ($urandom_range(1, 8) - 1) @(posedge clk);
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  // Compare each accepted result word with the oldest drained expectation
  always @(posedge clk) begin : check_results
    drain_word_t want;
    drain_word_t got;
    if (rst_n && m_valid && m_ready) begin
      got.mixed = m_tdata[15:0];
      got.slot = m_tdata[24:16];
      if (drained_q.size() == 0) begin
        err_cnt++;
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
          $display("unexpected word: mixed=%0d slot=%0d", got.mixed, got.slot);
      end else begin
        want = drained_q.pop_front();
        if (got.mixed !== want.mixed || got.slot !== want.slot) begin
          err_cnt++;
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("mismatch: expected mixed=%0d slot=%0d, got mixed=%0d slot=%0d",
                     want.mixed, want.slot, got.mixed, got.slot);
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_mix();
    test_backpressure();
    test_full_rate();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("** audio_mix_accumulate_saturate_core: PASSED **");
    end else begin
      $display("** audio_mix_accumulate_saturate_core: FAILED **");
    end
    $finish;
  end

endmodule
